// ----- src/rbsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared types and constants of the radius bucket spatial index
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int MAX_SPACES_DEF  = 16;
    localparam int MAX_MEMBERS_DEF = 32;
    localparam int ID_BITS_DEF     = 16;

    localparam int COORD_W = 16;
    localparam int RAD_W   = 8;
    localparam int FID_W   = 16;
    localparam int SIDX_W  = 4;

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_RETRIEVE = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_NOP      = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        K_JOINED  = 3'd0,
        K_NEW     = 3'd1,
        K_NEIGH   = 3'd2,
        K_NONE    = 3'd3,
        K_TFULL   = 3'd4,
        K_SFULL   = 3'd5,
        K_CLEARED = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [SIDX_W-1:0]  sidx;
        logic [FID_W-1:0]   nid;
        logic               last;
    } t_res;

endpackage

// ----- src/radius_bucket_spatial_index.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radius_bucket_spatial_index
// table of spheres with member lists: insert, neighbour retrieve and clear
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  input   | in        | i_valid / o_stall  | action, entity_id, pos_x/y/z, radius
//  result  | out       | o_valid / i_stall  | kind, space_index, neighbour_id, last
//
//  one item at a time; a lookup reads each space scanned from the space table,
//  then compares its squared distance through one register stage
//  retrieve walks the member list of a matching space, one member memory read
//  a cycle while no stalled result holds the walk
//  reset clears the space count and control only; memories hold no reset state
//  a stalled result holds the member scan until the output register frees
// ----------------------------------------------------------------------------
module radius_bucket_spatial_index #(
    parameter int MAX_SPACES  = rbsi_pkg::MAX_SPACES_DEF,
    parameter int MAX_MEMBERS = rbsi_pkg::MAX_MEMBERS_DEF,
    parameter int ID_BITS     = rbsi_pkg::ID_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_action,
    input  logic [rbsi_pkg::FID_W-1:0]           i_entity_id,
    input  logic signed [rbsi_pkg::COORD_W-1:0]  i_pos_x,
    input  logic signed [rbsi_pkg::COORD_W-1:0]  i_pos_y,
    input  logic signed [rbsi_pkg::COORD_W-1:0]  i_pos_z,
    input  logic [rbsi_pkg::RAD_W-1:0]           i_radius,
    // result channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [2:0]                           o_kind,
    output logic [rbsi_pkg::SIDX_W-1:0]          o_space_index,
    output logic [rbsi_pkg::FID_W-1:0]           o_neighbour_id,
    output logic                                 o_last
);
    // widths derived from the table geometry
    localparam int SW  = (MAX_SPACES > 1) ? $clog2(MAX_SPACES) : 1;
    localparam int CW  = $clog2(MAX_SPACES + 1);
    localparam int MW  = $clog2(MAX_MEMBERS + 1);
    localparam int JW  = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int MAW = (MAX_SPACES * MAX_MEMBERS > 1) ?
                         $clog2(MAX_SPACES * MAX_MEMBERS) : 1;
    localparam int IW  = (ID_BITS < rbsi_pkg::FID_W) ? ID_BITS : rbsi_pkg::FID_W;
    localparam int MDEPTH = MAX_SPACES * MAX_MEMBERS;

    typedef struct packed {
        logic signed [rbsi_pkg::COORD_W-1:0] cx;
        logic signed [rbsi_pkg::COORD_W-1:0] cy;
        logic signed [rbsi_pkg::COORD_W-1:0] cz;
        logic [rbsi_pkg::RAD_W-1:0]          rad;
        logic [MW-1:0]                       mcnt;
    } t_space;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,   // space entry on the read port, squares register
        S_CMP  = 6'b000100,   // distance compare, step or stop the scan
        S_DEC  = 6'b001000,   // update tables, set up the result
        S_MRD  = 6'b010000,   // walk the member list of the matched space
        S_EMIT = 6'b100000    // hand the prepared result to the output register
    } t_state;

    // memories
    t_space             m_space [MAX_SPACES];
    logic [IW-1:0]      m_member [MDEPTH];

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_idx, n_idx;
    logic               r_hit, n_hit;
    logic [MW-1:0]      r_j, n_j;
    logic               r_pend_v, n_pend_v;
    logic [IW-1:0]      r_pend, n_pend;
    rbsi_pkg::t_res     r_res, n_res;

    // latched item
    rbsi_pkg::t_action                    r_act;
    logic [IW-1:0]                        r_id;
    logic signed [rbsi_pkg::COORD_W-1:0]  r_px, r_py, r_pz;
    logic [rbsi_pkg::RAD_W-1:0]           r_rad;

    // memory ports
    t_space             r_sp_q;
    logic [IW-1:0]      r_mq;
    logic               w_swe;
    logic [SW-1:0]      w_swaddr;
    t_space             w_swdata;
    logic               w_mwe;
    logic [MAW-1:0]     w_mwaddr;
    logic [MAW-1:0]     w_mraddr;

    // output register
    logic               r_out_valid;
    rbsi_pkg::t_res     r_out;
    logic               w_emit;
    rbsi_pkg::t_res     w_emit_res;
    logic               w_slot_free;

    logic               w_accept;
    logic               w_within;
    logic               w_diff;
    logic               w_jlast;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_slot_free = !r_out_valid || !i_stall;

    // member list base of the current space plus the walk position
    assign w_mraddr = MAW'(MAW'(r_idx) * MAW'(MAX_MEMBERS)) + MAW'(n_j[JW-1:0]);

    // space table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            m_space[w_swaddr] <= w_swdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sp_q <= m_space[n_idx];
    end

    // member store
    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            m_member[w_mwaddr] <= r_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mq <= m_member[w_mraddr];
    end

    rbsi_dist u_dist (
        .i_clk    (i_clk),
        .i_pos_x  (r_px),
        .i_pos_y  (r_py),
        .i_pos_z  (r_pz),
        .i_cen_x  (r_sp_q.cx),
        .i_cen_y  (r_sp_q.cy),
        .i_cen_z  (r_sp_q.cz),
        .i_radius (r_sp_q.rad),
        .o_within (w_within)
    );

    assign w_diff  = (r_mq != r_id);
    assign w_jlast = ((r_j + MW'(1)) == r_sp_q.mcnt);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_j        = r_j;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_res      = r_res;
        w_swe      = 1'b0;
        w_swaddr   = r_idx;
        w_swdata   = r_sp_q;
        w_mwe      = 1'b0;
        w_mwaddr   = '0;
        w_emit     = 1'b0;
        w_emit_res = r_res;

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_hit = 1'b0;
                if (w_accept) begin
                    unique case (rbsi_pkg::t_action'(i_action))
                        rbsi_pkg::ACT_CLEAR: begin
                            n_count = '0;
                            n_res   = '{kind: rbsi_pkg::K_CLEARED, sidx: '0,
                                        nid: '0, last: 1'b1};
                            n_state = S_EMIT;
                        end
                        rbsi_pkg::ACT_INSERT, rbsi_pkg::ACT_RETRIEVE: begin
                            // empty table: nothing to scan
                            n_state = (r_count == '0) ? S_DEC : S_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD: begin
                n_state = S_CMP;
            end

            S_CMP: begin
                if (w_within) begin
                    n_hit   = 1'b1;
                    n_state = S_DEC;
                end else if ((CW'(r_idx) + CW'(1)) >= r_count) begin
                    n_state = S_DEC;
                end else begin
                    n_idx   = r_idx + SW'(1);
                    n_state = S_RD;
                end
            end

            S_DEC: begin
                n_state = S_EMIT;
                if (r_act == rbsi_pkg::ACT_INSERT) begin
                    if (r_hit) begin
                        if (r_sp_q.mcnt >= MW'(MAX_MEMBERS)) begin
                            n_res = '{kind: rbsi_pkg::K_SFULL,
                                      sidx: rbsi_pkg::SIDX_W'(r_idx),
                                      nid: '0, last: 1'b1};
                        end else begin
                            w_mwe         = 1'b1;
                            w_mwaddr      = MAW'(MAW'(r_idx) * MAW'(MAX_MEMBERS))
                                            + MAW'(r_sp_q.mcnt[JW-1:0]);
                            w_swe         = 1'b1;
                            w_swaddr      = r_idx;
                            w_swdata      = r_sp_q;
                            w_swdata.mcnt = r_sp_q.mcnt + MW'(1);
                            n_res = '{kind: rbsi_pkg::K_JOINED,
                                      sidx: rbsi_pkg::SIDX_W'(r_idx),
                                      nid: '0, last: 1'b1};
                        end
                    end else if (r_count >= CW'(MAX_SPACES)) begin
                        n_res = '{kind: rbsi_pkg::K_TFULL, sidx: '0,
                                  nid: '0, last: 1'b1};
                    end else begin
                        // open a new space with the asking id as first member
                        w_swe    = 1'b1;
                        w_swaddr = r_count[SW-1:0];
                        w_swdata = '{cx: r_px, cy: r_py, cz: r_pz,
                                     rad: r_rad, mcnt: MW'(1)};
                        w_mwe    = 1'b1;
                        w_mwaddr = MAW'(MAW'(r_count[SW-1:0]) * MAW'(MAX_MEMBERS));
                        n_count  = r_count + CW'(1);
                        n_res = '{kind: rbsi_pkg::K_NEW,
                                  sidx: rbsi_pkg::SIDX_W'(r_count[SW-1:0]),
                                  nid: '0, last: 1'b1};
                    end
                end else if (r_hit && (r_sp_q.mcnt != '0)) begin
                    n_j      = '0;
                    n_pend_v = 1'b0;
                    n_state  = S_MRD;
                end else begin
                    n_res = '{kind: rbsi_pkg::K_NONE,
                              sidx: r_hit ? rbsi_pkg::SIDX_W'(r_idx) : '0,
                              nid: '0, last: 1'b1};
                end
            end

            S_MRD: begin
                // one neighbour is held back so the final one can carry last
                if (w_diff && r_pend_v && !w_slot_free) begin
                    n_state = S_MRD;
                end else begin
                    if (w_diff) begin
                        if (r_pend_v) begin
                            w_emit     = 1'b1;
                            w_emit_res = '{kind: rbsi_pkg::K_NEIGH,
                                           sidx: rbsi_pkg::SIDX_W'(r_idx),
                                           nid: rbsi_pkg::FID_W'(r_pend),
                                           last: 1'b0};
                        end
                        n_pend   = r_mq;
                        n_pend_v = 1'b1;
                    end
                    if (w_jlast) begin
                        n_pend_v = 1'b0;
                        n_state  = S_EMIT;
                        if (w_diff || r_pend_v) begin
                            n_res = '{kind: rbsi_pkg::K_NEIGH,
                                      sidx: rbsi_pkg::SIDX_W'(r_idx),
                                      nid: rbsi_pkg::FID_W'(w_diff ? r_mq : r_pend),
                                      last: 1'b1};
                        end else begin
                            n_res = '{kind: rbsi_pkg::K_NONE,
                                      sidx: rbsi_pkg::SIDX_W'(r_idx),
                                      nid: '0, last: 1'b1};
                        end
                    end else begin
                        n_j = r_j + MW'(1);
                    end
                end
            end

            S_EMIT: begin
                if (w_slot_free) begin
                    w_emit     = 1'b1;
                    w_emit_res = r_res;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_hit  <= n_hit;
        r_j    <= n_j;
        r_pend <= n_pend;
        r_res  <= n_res;
        if (w_accept) begin
            r_act <= rbsi_pkg::t_action'(i_action);
            r_id  <= i_entity_id[IW-1:0];
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_pz  <= i_pos_z;
            r_rad <= i_radius;
        end
    end

    // output register, refilled in the cycle its transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_emit_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_space_index  = r_out.sidx;
    assign o_neighbour_id = r_out.nid;
    assign o_last         = r_out.last;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SPACES))
        else $error("space count beyond table size");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action == rbsi_pkg::ACT_CLEAR)) |=> (r_count == '0))
        else $error("clear left spaces in the table");

    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state == S_MRD))
        else $error("held neighbour outside the member walk");

    a_emit_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || !i_stall))
        else $error("result written over a stalled one");

endmodule

// ----- src/rbsi_dist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_dist
// squared distance test of a position against one sphere, one register stage
// ----------------------------------------------------------------------------
module rbsi_dist (
    input  logic                                   i_clk,
    input  logic signed [rbsi_pkg::COORD_W-1:0]    i_pos_x,
    input  logic signed [rbsi_pkg::COORD_W-1:0]    i_pos_y,
    input  logic signed [rbsi_pkg::COORD_W-1:0]    i_pos_z,
    input  logic signed [rbsi_pkg::COORD_W-1:0]    i_cen_x,
    input  logic signed [rbsi_pkg::COORD_W-1:0]    i_cen_y,
    input  logic signed [rbsi_pkg::COORD_W-1:0]    i_cen_z,
    input  logic        [rbsi_pkg::RAD_W-1:0]      i_radius,
    output logic                                   o_within
);
    localparam int DW = rbsi_pkg::COORD_W + 1;
    localparam int SQ = 2 * rbsi_pkg::COORD_W;

    logic signed [DW-1:0] w_dx, w_dy, w_dz;
    logic [SQ-1:0]        r_sq_x, r_sq_y, r_sq_z;
    logic [SQ-1:0]        r_r2;
    logic [SQ+1:0]        w_sum;

    assign w_dx = DW'(i_pos_x) - DW'(i_cen_x);
    assign w_dy = DW'(i_pos_y) - DW'(i_cen_y);
    assign w_dz = DW'(i_pos_z) - DW'(i_cen_z);

    // |d| fits in 16 bits, so each square fits in 32
    always_ff @(posedge i_clk) begin
        r_sq_x <= SQ'(w_dx * w_dx);
        r_sq_y <= SQ'(w_dy * w_dy);
        r_sq_z <= SQ'(w_dz * w_dz);
        r_r2   <= {16'(i_radius) * 16'(i_radius), 16'd0};
    end

    assign w_sum    = (SQ+2)'(r_sq_x) + (SQ+2)'(r_sq_y) + (SQ+2)'(r_sq_z);
    assign o_within = w_sum <= (SQ+2)'(r_r2);

endmodule

// ----- bench/rbsi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_checker
// watches both channels of the spatial index, keeps its own copy of the
// space table, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module rbsi_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_entity_id,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_pos_z,
    input  logic [7:0]  i_radius,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [2:0]  i_kind,
    input  logic [3:0]  i_space_index,
    input  logic [15:0] i_neighbour_id,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending
);

    localparam int NSP = rbsi_pkg::MAX_SPACES_DEF;
    localparam int NMB = rbsi_pkg::MAX_MEMBERS_DEF;

    int                 n_spaces;
    logic signed [16:0] cx [NSP];
    logic signed [16:0] cy [NSP];
    logic signed [16:0] cz [NSP];
    logic [7:0]         crad [NSP];
    int                 n_members [NSP];
    logic [15:0]        members [NSP][NMB];
    rbsi_pkg::t_res     expected_q [$];

    function automatic logic [49:0] sq(logic signed [16:0] a, logic signed [16:0] b);
        logic signed [17:0] d;
        d = a - b;
        return 50'(d * d);
    endfunction

    task automatic push_res(rbsi_pkg::t_kind k, int s, logic [15:0] n, logic l);
        rbsi_pkg::t_res r;
        r.kind = k;
        r.sidx = 4'(s);
        r.nid  = n;
        r.last = l;
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic predict_item(logic [1:0] act, logic [15:0] id,
                                logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                logic [7:0] rad);
        logic signed [16:0] x, y, z;
        logic [49:0]        d2, r2;
        logic [16:0]        rq;
        int                 hit, cnt;
        x = 17'(signed'(px));
        y = 17'(signed'(py));
        z = 17'(signed'(pz));
        hit = -1;
        cnt = 0;
        for (int i = 0; i < n_spaces; i++) begin
            if (hit < 0) begin
                d2 = sq(x, cx[i]) + sq(y, cy[i]) + sq(z, cz[i]);
                rq = {1'b0, crad[i], 8'd0};
                r2 = 50'(rq) * 50'(rq);
                if (d2 <= r2) hit = i;
            end
        end
        case (act)
            rbsi_pkg::ACT_INSERT: begin
                if (hit >= 0) begin
                    if (n_members[hit] >= NMB) begin
                        push_res(rbsi_pkg::K_SFULL, hit, 0, 1'b1);
                    end else begin
                        members[hit][n_members[hit]] = id;
                        n_members[hit]++;
                        push_res(rbsi_pkg::K_JOINED, hit, 0, 1'b1);
                    end
                end else if (n_spaces >= NSP) begin
                    push_res(rbsi_pkg::K_TFULL, 0, 0, 1'b1);
                end else begin
                    cx[n_spaces] = x;
                    cy[n_spaces] = y;
                    cz[n_spaces] = z;
                    crad[n_spaces] = rad;
                    members[n_spaces][0] = id;
                    n_members[n_spaces] = 1;
                    push_res(rbsi_pkg::K_NEW, n_spaces, 0, 1'b1);
                    n_spaces++;
                end
            end
            rbsi_pkg::ACT_RETRIEVE: begin
                if (hit >= 0) begin
                    for (int j = 0; j < n_members[hit]; j++) begin
                        if (members[hit][j] != id) begin
                            push_res(rbsi_pkg::K_NEIGH, hit, members[hit][j], 1'b0);
                            cnt++;
                        end
                    end
                end
                if (cnt == 0) push_res(rbsi_pkg::K_NONE, (hit >= 0) ? hit : 0, 0, 1'b1);
                else expected_q[$].last = 1'b1;
            end
            rbsi_pkg::ACT_CLEAR: begin
                n_spaces = 0;
                push_res(rbsi_pkg::K_CLEARED, 0, 0, 1'b1);
            end
            default: ;  // action three does nothing
        endcase
    endtask

    always @(posedge i_clk) begin
        rbsi_pkg::t_res e;
        if (!i_rst_n) begin
            n_spaces = 0;
            o_errors <= 0;
        end else begin
            if (i_valid && !i_stall_in)
                predict_item(i_action, i_entity_id, i_pos_x, i_pos_y, i_pos_z, i_radius);
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (i_kind !== e.kind || i_space_index !== e.sidx ||
                        i_neighbour_id !== e.nid || i_last !== e.last) begin
                        if (i_kind !== e.kind)
                            $error("kind: expected %0d actual %0d", e.kind, i_kind);
                        if (i_space_index !== e.sidx)
                            $error("space_index: expected %0d actual %0d",
                                   e.sidx, i_space_index);
                        if (i_neighbour_id !== e.nid)
                            $error("neighbour_id: expected %0d actual %0d",
                                   e.nid, i_neighbour_id);
                        if (i_last !== e.last)
                            $error("last: expected %0d actual %0d", e.last, i_last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_q.size();

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives insert, retrieve, clear and ignored transactions into the spatial
// index with bursty input and random output stalls; the checker predicts
// ----------------------------------------------------------------------------
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [15:0] i_entity_id;
    logic [15:0] i_pos_x, i_pos_y, i_pos_z;
    logic [7:0]  i_radius;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_kind;
    logic [3:0]  o_space_index;
    logic [15:0] o_neighbour_id;
    logic        o_last;
    int          err_count;
    int          pending;
    int          stall_mode = 0;

    // a handful of anchor points so random items land inside known spaces
    logic [15:0] anchor_x [8];
    logic [15:0] anchor_y [8];
    logic [15:0] anchor_z [8];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    radius_bucket_spatial_index uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_action), .i_entity_id(i_entity_id),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_radius(i_radius),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_kind(o_kind), .o_space_index(o_space_index),
        .o_neighbour_id(o_neighbour_id), .o_last(o_last)
    );

    rbsi_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_action(i_action), .i_entity_id(i_entity_id),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_radius(i_radius),
        .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_kind(o_kind), .i_space_index(o_space_index),
        .i_neighbour_id(o_neighbour_id), .i_last(o_last),
        .o_errors(err_count), .o_pending(pending)
    );

    // receiver stall pattern: switches between no stall, light and heavy
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // one transaction: present at the falling edge, hold until accepted
    task automatic send(logic [1:0] act, logic [15:0] id, logic [15:0] px,
                        logic [15:0] py, logic [15:0] pz, logic [7:0] rad);
        i_valid     <= 1'b1;
        i_action    <= act;
        i_entity_id <= id;
        i_pos_x     <= px;
        i_pos_y     <= py;
        i_pos_z     <= pz;
        i_radius    <= rad;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 6);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // random item: mostly near an anchor so lookups hit, some pure noise
    task automatic send_random();
        int          a, sel;
        logic [1:0]  act;
        logic [15:0] px, py, pz;
        sel = $urandom_range(0, 99);
        if (sel < 60)      act = rbsi_pkg::ACT_INSERT;
        else if (sel < 92) act = rbsi_pkg::ACT_RETRIEVE;
        else if (sel < 96) act = rbsi_pkg::ACT_CLEAR;
        else               act = rbsi_pkg::ACT_NOP;
        a = $urandom_range(0, 7);
        if ($urandom_range(0, 4) == 0) begin
            px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
        end else begin
            px = anchor_x[a] + 16'($urandom_range(0, 1023)) - 16'd512;
            py = anchor_y[a] + 16'($urandom_range(0, 1023)) - 16'd512;
            pz = anchor_z[a] + 16'($urandom_range(0, 1023)) - 16'd512;
        end
        // small id pool so a retrieve sometimes finds its own id
        send(act, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
             px, py, pz, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int burst;
        i_valid     = 1'b0;
        i_action    = rbsi_pkg::ACT_INSERT;
        i_entity_id = '0;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_pos_z     = '0;
        i_radius    = '0;
        i_rst_n     = 1'b0;
        for (int k = 0; k < 8; k++) begin
            anchor_x[k] = 16'($urandom);
            anchor_y[k] = 16'($urandom);
            anchor_z[k] = 16'($urandom);
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, extremes, radius zero, full space, full table
        send(rbsi_pkg::ACT_RETRIEVE, 16'd7, 16'h0000, 16'h0000, 16'h0000, 8'd0);
        send(rbsi_pkg::ACT_INSERT, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 8'd255);
        send(rbsi_pkg::ACT_INSERT, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd0);
        send(rbsi_pkg::ACT_RETRIEVE, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 8'd0);
        send(rbsi_pkg::ACT_INSERT, 16'h1234, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd9);
        send(rbsi_pkg::ACT_RETRIEVE, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'd0);
        send(rbsi_pkg::ACT_NOP, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA);
        send(rbsi_pkg::ACT_CLEAR, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55);
        for (int k = 0; k < 33; k++)
            send(rbsi_pkg::ACT_INSERT, 16'(k), 16'h0100, 16'h0000, 16'h0000, 8'd4);
        send(rbsi_pkg::ACT_RETRIEVE, 16'd3, 16'h0000, 16'h0000, 16'h0000, 8'd0);
        for (int k = 1; k < 17; k++)
            send(rbsi_pkg::ACT_INSERT, 16'(k), 16'(k * 4096), 16'h4000, 16'hC000, 8'd1);
        send(rbsi_pkg::ACT_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);

        // random part: bursts, mostly separated by gaps
        for (int k = 0; k < 340; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++) begin
                send_random();
                k++;
            end
            if ($urandom_range(0, 2) != 0) idle_gap();
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
src/rbsi_pkg.sv
src/rbsi_dist.sv
src/radius_bucket_spatial_index.sv
bench/rbsi_checker.sv
bench/tb_top.sv
